FILE: rtl/lobt_pkg.sv
// Shared types and constants for the order book table.
`timescale 1ns / 1ps
package lobt_pkg;
   localparam int MAX_ORDERS_DEF = 256;
   localparam int FIFO_DEPTH = 2;

   typedef enum logic [1:0] {
      REQ_ADD    = 2'd0,
      REQ_CANCEL = 2'd1,
      REQ_MODIFY = 2'd2,
      REQ_NONE   = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_DONE = 2'd0,
      ST_DUP  = 2'd1,
      ST_UNK  = 2'd2,
      ST_FULL = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [63:0] ord_key;
      logic        side;
      logic [31:0] price;
      logic [31:0] quantity;
      logic [63:0] timestamp;
   } req_type_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] best_bid;
      logic        bid_present;
      logic [31:0] best_ask;
      logic        ask_present;
      logic [8:0]  order_count;
   } rsp_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MATCH,
      BK_UPDATE,
      BK_REDUCE,
      BK_FINAL,
      BK_OUT
   } back_state_type;
endpackage

FILE: rtl/lobt_front.sv
// Front end: short request queue.
`timescale 1ns / 1ps
module lobt_front
   import lobt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_type_type req_data,
   output logic         q_valid,
   input  logic         q_take,
   output req_type_type q_data
);
   req_type_type mem_ff [FIFO_DEPTH];
   logic         wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic         push;

   assign req_stall = (cnt_ff == 2'(FIFO_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_data    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = (q_take && q_valid) ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(q_take && q_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) mem_ff[wr_ptr_ff] <= req_data;
   end
endmodule

FILE: rtl/lobt_back.sv
// Back end: slot cells, match, update, best-price reduction, result register.
`timescale 1ns / 1ps
module lobt_back
   import lobt_pkg::*;
#(
   parameter int MAX_ORDERS = MAX_ORDERS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         q_valid,
   output logic         q_take,
   input  req_type_type q_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_type      rsp_data
);
   localparam int IW = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;
   localparam int CW = $clog2(MAX_ORDERS + 1);
   // reduction tree: leaves padded to a power of two, levels split in two halves around the part_ff register
   localparam int NP    = 1 << IW;
   localparam int L1    = IW / 2;
   localparam int NPART = NP >> L1;

   typedef struct packed {
      logic [31:0]   bid;
      logic          hb;
      logic [31:0]   ask;
      logic          ha;
      logic [CW-1:0] cnt;
   } node_type;

   function automatic node_type node_merge(node_type a, node_type b);
      node_type m;
      m.hb  = a.hb | b.hb;
      m.bid = (a.hb && (!b.hb || a.bid >= b.bid)) ? a.bid : b.bid;
      m.ha  = a.ha | b.ha;
      m.ask = (a.ha && (!b.ha || a.ask <= b.ask)) ? a.ask : b.ask;
      m.cnt = a.cnt + b.cnt;
      return m;
   endfunction

   logic [MAX_ORDERS-1:0] valid_ff;
   logic [63:0] id_ff    [MAX_ORDERS];
   logic        side_ff  [MAX_ORDERS];
   logic [31:0] price_ff [MAX_ORDERS];
   logic [31:0] qty_ff   [MAX_ORDERS];
   logic [63:0] time_ff  [MAX_ORDERS];
   logic [31:0] seq_ff   [MAX_ORDERS];
   logic [31:0] next_seq_ff;

   back_state_type state_ff, state_in;
   req_type_type   cur_ff;
   logic           found_ff, free_ok_ff;
   logic [IW-1:0]  hit_idx_ff, free_idx_ff;
   status_type     status_ff, status_c;
   logic           out_valid_ff;
   rsp_type        out_ff;
   node_type       part_ff [NPART];

   // per-cell match (parallel compares)
   logic [MAX_ORDERS-1:0] hit_c;
   always_comb begin
      for (int i = 0; i < MAX_ORDERS; i++)
         hit_c[i] = valid_ff[i] && (id_ff[i] == cur_ff.ord_key);
   end

   // ids are unique among valid cells, so the hit vector has at most one bit set
   logic [IW-1:0] hit_idx_c, free_idx_c;
   logic          free_c;
   always_comb begin
      hit_idx_c = '0; free_idx_c = '0; free_c = 1'b0;
      for (int i = MAX_ORDERS - 1; i >= 0; i--) begin
         if (hit_c[i]) hit_idx_c = hit_idx_c | IW'(i);
         if (!valid_ff[i]) begin
            free_idx_c = IW'(i); free_c = 1'b1;
         end
      end
   end

   // first half of the best-price and count tree
   node_type part_c [NPART];
   always_comb begin
      node_type t [NP];
      for (int i = 0; i < NP; i++) begin
         t[i] = '0;
         if (i < MAX_ORDERS) begin
            if (valid_ff[i]) begin
               t[i].cnt = CW'(1);
               if (!side_ff[i]) begin
                  t[i].bid = price_ff[i]; t[i].hb = 1'b1;
               end else begin
                  t[i].ask = price_ff[i]; t[i].ha = 1'b1;
               end
            end
         end
      end
      for (int l = 0; l < L1; l++)
         for (int i = 0; i < (NP >> (l + 1)); i++)
            t[i] = node_merge(t[2 * i], t[2 * i + 1]);
      for (int i = 0; i < NPART; i++)
         part_c[i] = t[i];
   end

   // second half on the registered partials
   node_type root_c;
   always_comb begin
      node_type u [NPART];
      for (int i = 0; i < NPART; i++)
         u[i] = part_ff[i];
      for (int l = 0; l < IW - L1; l++)
         for (int i = 0; i < (NPART >> (l + 1)); i++)
            u[i] = node_merge(u[2 * i], u[2 * i + 1]);
      root_c = u[0];
   end

   assign q_take    = (state_ff == BK_IDLE) && q_valid;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE:   if (q_valid) state_in = BK_MATCH;
         BK_MATCH:  state_in = BK_UPDATE;
         BK_UPDATE: state_in = BK_REDUCE;
         BK_REDUCE: state_in = BK_FINAL;
         BK_FINAL:  state_in = BK_OUT;
         BK_OUT:    if (!rsp_stall) state_in = BK_IDLE;
         default:   state_in = BK_IDLE;
      endcase
   end

   logic lose;
   assign lose = (price_ff[hit_idx_ff] != cur_ff.price)
              || (cur_ff.quantity > qty_ff[hit_idx_ff]);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         valid_ff     <= '0;
         next_seq_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == BK_FINAL) out_valid_ff <= 1'b1;
         else if (out_valid_ff && !rsp_stall) out_valid_ff <= 1'b0;
         if (state_ff == BK_UPDATE) begin
            unique case (req_kind_type'(cur_ff.req_type))
               REQ_ADD: if (!found_ff && free_ok_ff) begin
                  valid_ff[free_idx_ff] <= 1'b1;
                  next_seq_ff <= next_seq_ff + 32'd1;
               end
               REQ_CANCEL: if (found_ff) valid_ff[hit_idx_ff] <= 1'b0;
               REQ_MODIFY: if (found_ff && lose) next_seq_ff <= next_seq_ff + 32'd1;
               default: ;
            endcase
         end
      end
      if (q_take) cur_ff <= q_data;
      if (state_ff == BK_UPDATE) begin
         status_ff <= status_c;
         unique case (req_kind_type'(cur_ff.req_type))
            REQ_ADD: if (!found_ff && free_ok_ff) begin
               id_ff[free_idx_ff]    <= cur_ff.ord_key;
               side_ff[free_idx_ff]  <= cur_ff.side;
               price_ff[free_idx_ff] <= cur_ff.price;
               qty_ff[free_idx_ff]   <= cur_ff.quantity;
               time_ff[free_idx_ff]  <= cur_ff.timestamp;
               seq_ff[free_idx_ff]   <= next_seq_ff;
            end
            REQ_MODIFY: if (found_ff) begin
               price_ff[hit_idx_ff] <= cur_ff.price;
               qty_ff[hit_idx_ff]   <= cur_ff.quantity;
               time_ff[hit_idx_ff]  <= cur_ff.timestamp;
               if (lose) seq_ff[hit_idx_ff] <= next_seq_ff;
            end
            default: ;
         endcase
      end
      if (state_ff == BK_REDUCE) begin
         for (int i = 0; i < NPART; i++)
            part_ff[i] <= part_c[i];
      end
      if (state_ff == BK_FINAL) begin
         out_ff.status      <= status_ff;
         out_ff.best_bid    <= root_c.bid;
         out_ff.bid_present <= root_c.hb;
         out_ff.best_ask    <= root_c.ask;
         out_ff.ask_present <= root_c.ha;
         out_ff.order_count <= 9'(root_c.cnt);
      end
   end

   // match result and free slot, registered for the update cycle
   always_ff @(posedge clock) begin
      if (state_ff == BK_MATCH) begin
         found_ff   <= |hit_c;
         hit_idx_ff <= hit_idx_c;
      end
      free_ok_ff  <= free_c;
      free_idx_ff <= free_idx_c;
   end

   always_comb begin
      unique case (req_kind_type'(cur_ff.req_type))
         REQ_ADD:    status_c = found_ff ? ST_DUP : (free_ok_ff ? ST_DONE : ST_FULL);
         REQ_CANCEL: status_c = found_ff ? ST_DONE : ST_UNK;
         REQ_MODIFY: status_c = found_ff ? ST_DONE : ST_UNK;
         default:    status_c = ST_DONE;
      endcase
   end
endmodule

FILE: rtl/limit_order_book_table_unit.sv
// Top level of the limit order book table.
`timescale 1ns / 1ps
// channel | dir | payload        | handshake
// req_    | in  | req_type_type  | req_valid / req_stall
// rsp_    | out | rsp_type       | rsp_valid / rsp_stall
// The back end takes a request from the queue, then steps through BK_MATCH
// (id match over all slot cells), BK_UPDATE (slot update), BK_REDUCE and
// BK_FINAL (the two halves of the best-price tree); rsp_valid rises in
// BK_OUT, and the next take follows the rsp_ transfer.
// The front queue (2 deep) keeps taking requests while the back end works.
// Reset is synchronous and active high; it clears slot valid bits at once.
// A stalled result holds the back end; the queue then fills and stalls req_.
module limit_order_book_table_unit
   import lobt_pkg::*;
#(
   parameter int MAX_ORDERS = MAX_ORDERS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_type_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_type      rsp_data
);
   logic         q_valid, q_take;
   req_type_type q_data;

   lobt_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .q_valid(q_valid), .q_take(q_take), .q_data(q_data)
   );

   lobt_back #(.MAX_ORDERS(MAX_ORDERS)) u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_take(q_take), .q_data(q_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );
endmodule
